/* sv/segment_rect_clip_length_top_assert.svh */
// assertion macros for the segment clip length block
`ifndef SEGMENT_RECT_CLIP_LENGTH_TOP_ASSERT_SVH
`define SEGMENT_RECT_CLIP_LENGTH_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define SRCL_ALWAYS(lbl, ck, rn, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (c)) \
		else $error("srcl: invariant violated");

// antecedent implies consequent at the same edge
`define SRCL_IMPLY(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
		else $error("srcl: implication violated");

`endif

/* sv/srcl_pkg.sv */
package srcl_pkg;

	localparam int CW  = 32;          // coordinate width
	localparam int LW  = 34;          // length width
	localparam int QW  = CW + 2;      // quotient bits, one divider cell each
	localparam int RW  = CW + 2;      // divider remainder width
	localparam int DW  = 2 * CW + 2;  // dividend width
	localparam int PW  = CW + 3;      // clipped point width
	localparam int RB  = CW + 1;      // root bits, one sqrt cell each
	localparam int SQW = 2 * RB;      // radicand width
	localparam int RRW = RB + 3;      // sqrt remainder width
	localparam int LAT = 2 * QW + RB + 11;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic                 early;
		logic                 invalid;
		logic [LW-1:0]        len;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW:0]   dx;
		logic signed [CW:0]   dy;
		logic [1:0][PW-1:0]   px;
		logic [1:0][PW-1:0]   py;
		logic [1:0]           clip;
		logic [1:0]           neg;
	} pl_t;

	typedef struct packed {
		logic [1:0][RW-1:0] rem;
		logic [1:0][QW-1:0] low;
		logic [1:0][QW-1:0] quo;
		logic [CW:0]        dvs;
	} div_t;

	typedef struct packed {
		logic          early;
		logic          invalid;
		logic [LW-1:0] len;
	} res_t;

	typedef struct packed {
		logic [RRW-1:0] rem;
		logic [SQW-1:0] v;
		logic [RB-1:0]  root;
	} sq_t;

endpackage

/* sv/srcl_div_cell.sv */
module srcl_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_i,
	input  srcl_pkg::pl_t     pl_i,
	input  srcl_pkg::div_t    dv_i,
	output logic              vld_q,
	output srcl_pkg::pl_t     pl_q,
	output srcl_pkg::div_t    dv_q
);

	logic [1:0][srcl_pkg::RW-1:0] cand;
	logic [1:0]                   ge;
	srcl_pkg::div_t               nxt;

	// one restoring step per lane, both lanes share the divisor
	always_comb begin
		nxt = dv_i;
		for (int k = 0; k < 2; k++) begin
			cand[k] = {dv_i.rem[k][srcl_pkg::RW-2:0], dv_i.low[k][srcl_pkg::QW-1]};
			ge[k] = cand[k] >= srcl_pkg::RW'(dv_i.dvs);
			nxt.rem[k] = ge[k] ? cand[k] - srcl_pkg::RW'(dv_i.dvs) : cand[k];
			nxt.low[k] = {dv_i.low[k][srcl_pkg::QW-2:0], 1'b0};
			nxt.quo[k] = {dv_i.quo[k][srcl_pkg::QW-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		pl_q <= pl_i;
		dv_q <= nxt;
	end

endmodule

/* sv/srcl_sqrt_cell.sv */
module srcl_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_i,
	input  srcl_pkg::res_t res_i,
	input  srcl_pkg::sq_t  sq_i,
	output logic           vld_q,
	output srcl_pkg::res_t res_q,
	output srcl_pkg::sq_t  sq_q
);

	logic [srcl_pkg::RRW-1:0] cand;
	logic [srcl_pkg::RRW-1:0] trial;
	logic                     ge;
	srcl_pkg::sq_t            nxt;

	// one root bit per cell, two radicand bits shifted in
	always_comb begin
		cand  = {sq_i.rem[srcl_pkg::RRW-3:0], sq_i.v[srcl_pkg::SQW-1:srcl_pkg::SQW-2]};
		trial = srcl_pkg::RRW'({sq_i.root, 2'b01});
		ge    = cand >= trial;
		nxt.rem  = ge ? cand - trial : cand;
		nxt.v    = {sq_i.v[srcl_pkg::SQW-3:0], 2'b00};
		nxt.root = {sq_i.root[srcl_pkg::RB-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_i;
		sq_q  <= nxt;
	end

endmodule

/* sv/segment_rect_clip_length_top.sv */
// a taken beat passes through two rows of 34 divider cells, one row of 33 square root
// cells and 11 other stages before its result strobes on done
// throughput: one segment per cycle, busy stays low, nothing holds the chain
// reset: arst_n clears all stage valid bits and the four rectangle registers to 0
// results leave on done for one cycle; the receiver cannot stall
module segment_rect_clip_length_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic signed [srcl_pkg::CW-1:0] start_x,
	input  logic signed [srcl_pkg::CW-1:0] start_y,
	input  logic signed [srcl_pkg::CW-1:0] end_x,
	input  logic signed [srcl_pkg::CW-1:0] end_y,
	// result side
	output logic                       done,
	output logic [srcl_pkg::LW-1:0]    inside_length,
	output logic                       rect_invalid
);

	typedef enum logic [1:0] {
		REG_X_MIN = 2'd0,
		REG_X_MAX = 2'd1,
		REG_Y_MIN = 2'd2,
		REG_Y_MAX = 2'd3
	} reg_idx_t;

	localparam int CW  = srcl_pkg::CW;
	localparam int PW  = srcl_pkg::PW;
	localparam int QW  = srcl_pkg::QW;
	localparam int RB  = srcl_pkg::RB;
	localparam int LW  = srcl_pkg::LW;
	localparam int DW  = srcl_pkg::DW;
	localparam int RW  = srcl_pkg::RW;
	localparam int SQW = srcl_pkg::SQW;
	localparam int RRW = srcl_pkg::RRW;

	// sign extend a coordinate by one bit
	function automatic logic signed [CW:0] ext1(input logic signed [CW-1:0] c);
		ext1 = {c[CW-1], c};
	endfunction

	// sign extend a coordinate to clipped point width
	function automatic logic signed [PW-1:0] extw(input logic signed [CW-1:0] c);
		extw = {{(PW-CW){c[CW-1]}}, c};
	endfunction

	function automatic logic [CW:0] mag1(input logic signed [CW:0] v);
		mag1 = v[CW] ? (CW+1)'(0) - v : v;
	endfunction

	// ---------------------------------------------------------------
	// rectangle registers and config port
	// ---------------------------------------------------------------
	srcl_pkg::coord_t x_min_q, x_max_q, y_min_q, y_max_q;
	reg_idx_t         cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (cfg_idx)
				REG_X_MIN: x_min_q <= pwdata;
				REG_X_MAX: x_max_q <= pwdata;
				REG_Y_MIN: y_min_q <= pwdata;
				REG_Y_MAX: y_max_q <= pwdata;
				default:   x_min_q <= x_min_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_X_MIN: prdata = x_min_q;
			REG_X_MAX: prdata = x_max_q;
			REG_Y_MIN: prdata = y_min_q;
			REG_Y_MAX: prdata = y_max_q;
			default:   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// s1: input beat register
	// ---------------------------------------------------------------
	logic                 v_s1;
	srcl_pkg::coord_t     sx_s1, sy_s1, ex_s1, ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= start_x;
		sy_s1 <= start_y;
		ex_s1 <= end_x;
		ey_s1 <= end_y;
	end

	// ---------------------------------------------------------------
	// s2: classify, clamp axis-aligned segments, pick x clip edges
	// ---------------------------------------------------------------
	srcl_pkg::pl_t        pl_c1;
	logic [1:0][CW:0]     mo_c1;
	logic                 inv_c1, rej_c1, vert_c1, horz_c1;
	logic signed [CW:0]   ca_c1, cb_c1, cd_c1, offx_c1;
	srcl_pkg::coord_t     pxk_c1, pyk_c1, tx_c1;
	logic                 cx_c1;

	always_comb begin
		inv_c1  = (x_min_q > x_max_q) || (y_min_q > y_max_q);
		rej_c1  = (sx_s1 < x_min_q && ex_s1 < x_min_q) || (sx_s1 > x_max_q && ex_s1 > x_max_q) ||
		          (sy_s1 < y_min_q && ey_s1 < y_min_q) || (sy_s1 > y_max_q && ey_s1 > y_max_q);
		vert_c1 = sx_s1 == ex_s1;
		horz_c1 = sy_s1 == ey_s1;

		// clamp along the axis that moves
		if (vert_c1) begin
			ca_c1 = sy_s1 > y_max_q ? ext1(y_max_q) : (sy_s1 < y_min_q ? ext1(y_min_q) : ext1(sy_s1));
			cb_c1 = ey_s1 > y_max_q ? ext1(y_max_q) : (ey_s1 < y_min_q ? ext1(y_min_q) : ext1(ey_s1));
		end else begin
			ca_c1 = sx_s1 > x_max_q ? ext1(x_max_q) : (sx_s1 < x_min_q ? ext1(x_min_q) : ext1(sx_s1));
			cb_c1 = ex_s1 > x_max_q ? ext1(x_max_q) : (ex_s1 < x_min_q ? ext1(x_min_q) : ext1(ex_s1));
		end
		cd_c1 = cb_c1 - ca_c1;

		pl_c1.early   = inv_c1 || rej_c1 || vert_c1 || horz_c1;
		pl_c1.invalid = inv_c1;
		if (inv_c1 || rej_c1) begin
			pl_c1.len = '0;
		end else if (vert_c1) begin
			pl_c1.len = (sx_s1 < x_min_q || sx_s1 > x_max_q) ? '0 : LW'(mag1(cd_c1));
		end else if (horz_c1) begin
			pl_c1.len = (sy_s1 < y_min_q || sy_s1 > y_max_q) ? '0 : LW'(mag1(cd_c1));
		end else begin
			pl_c1.len = '0;
		end

		pl_c1.sx = sx_s1;
		pl_c1.sy = sy_s1;
		pl_c1.dx = ext1(ex_s1) - ext1(sx_s1);
		pl_c1.dy = ext1(ey_s1) - ext1(sy_s1);

		pxk_c1 = sx_s1;
		pyk_c1 = sy_s1;
		tx_c1  = x_min_q;
		cx_c1  = 1'b0;
		offx_c1 = '0;
		for (int k = 0; k < 2; k++) begin
			pxk_c1 = (k == 0) ? sx_s1 : ex_s1;
			pyk_c1 = (k == 0) ? sy_s1 : ey_s1;
			cx_c1  = pxk_c1 < x_min_q || pxk_c1 > x_max_q;
			tx_c1  = pxk_c1 < x_min_q ? x_min_q : x_max_q;
			offx_c1 = ext1(tx_c1) - ext1(sx_s1);
			pl_c1.px[k]   = cx_c1 ? extw(tx_c1) : extw(pxk_c1);
			pl_c1.py[k]   = extw(pyk_c1);
			pl_c1.clip[k] = cx_c1;
			pl_c1.neg[k]  = offx_c1[CW] ^ pl_c1.dy[CW] ^ pl_c1.dx[CW];
			mo_c1[k]      = mag1(offx_c1);
		end
	end

	logic             v_s2;
	srcl_pkg::pl_t    pl_s2;
	logic [1:0][CW:0] mo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pl_s2 <= pl_c1;
		mo_s2 <= mo_c1;
	end

	// ---------------------------------------------------------------
	// s3: offset times |dy| for both endpoints
	// ---------------------------------------------------------------
	logic                v_s3;
	srcl_pkg::pl_t       pl_s3;
	logic [1:0][DW-1:0]  prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pl_s3 <= pl_s2;
		for (int k = 0; k < 2; k++) begin
			prod_s3[k] <= DW'(mo_s2[k]) * DW'(mag1(pl_s2.dy));
		end
	end

	// ---------------------------------------------------------------
	// x clip divider row: product / |dx|, one quotient bit per cell
	// ---------------------------------------------------------------
	logic                vx_d [0:QW];
	srcl_pkg::pl_t       plx_d[0:QW];
	srcl_pkg::div_t      dvx_d[0:QW];

	always_comb begin
		vx_d[0]  = v_s3;
		plx_d[0] = pl_s3;
		for (int k = 0; k < 2; k++) begin
			dvx_d[0].rem[k] = RW'(prod_s3[k][DW-1:QW]);
			dvx_d[0].low[k] = prod_s3[k][QW-1:0];
			dvx_d[0].quo[k] = '0;
		end
		dvx_d[0].dvs = mag1(pl_s3.dx);
	end

	for (genvar i = 0; i < QW; i++) begin : g_xdiv
		srcl_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (vx_d[i]),
			.pl_i  (plx_d[i]),
			.dv_i  (dvx_d[i]),
			.vld_q (vx_d[i+1]),
			.pl_q  (plx_d[i+1]),
			.dv_q  (dvx_d[i+1])
		);
	end

	// ---------------------------------------------------------------
	// xe: new y of x-clipped endpoints
	// ---------------------------------------------------------------
	srcl_pkg::pl_t     pl_c2;
	logic [PW-1:0]     qx_c2;

	always_comb begin
		pl_c2 = plx_d[QW];
		qx_c2 = '0;
		for (int k = 0; k < 2; k++) begin
			qx_c2 = PW'(dvx_d[QW].quo[k]);
			if (plx_d[QW].clip[k]) begin
				pl_c2.py[k] = plx_d[QW].neg[k] ? extw(plx_d[QW].sy) - qx_c2
				                               : extw(plx_d[QW].sy) + qx_c2;
			end
		end
	end

	logic          v_xe;
	srcl_pkg::pl_t pl_xe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_xe <= 1'b0;
		end else begin
			v_xe <= vx_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		pl_xe <= pl_c2;
	end

	// ---------------------------------------------------------------
	// y1: pick y clip edges
	// ---------------------------------------------------------------
	srcl_pkg::pl_t      pl_c3;
	logic [1:0][CW:0]   mo_c3;
	logic signed [PW-1:0] pyk_c3;
	srcl_pkg::coord_t   ty_c3;
	logic               cy_c3;
	logic signed [CW:0] offy_c3;

	always_comb begin
		pl_c3   = pl_xe;
		pyk_c3  = '0;
		ty_c3   = y_min_q;
		cy_c3   = 1'b0;
		offy_c3 = '0;
		for (int k = 0; k < 2; k++) begin
			pyk_c3  = $signed(pl_xe.py[k]);
			cy_c3   = pyk_c3 < extw(y_min_q) || pyk_c3 > extw(y_max_q);
			ty_c3   = pyk_c3 < extw(y_min_q) ? y_min_q : y_max_q;
			offy_c3 = ext1(ty_c3) - ext1(pl_xe.sy);
			if (cy_c3) begin
				pl_c3.py[k] = extw(ty_c3);
			end
			pl_c3.clip[k] = cy_c3;
			pl_c3.neg[k]  = offy_c3[CW] ^ pl_xe.dx[CW] ^ pl_xe.dy[CW];
			mo_c3[k]      = mag1(offy_c3);
		end
	end

	logic             v_y1;
	srcl_pkg::pl_t    pl_y1;
	logic [1:0][CW:0] mo_y1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_y1 <= 1'b0;
		end else begin
			v_y1 <= v_xe;
		end
	end

	always_ff @(posedge clk) begin
		pl_y1 <= pl_c3;
		mo_y1 <= mo_c3;
	end

	// ---------------------------------------------------------------
	// y2: offset times |dx|
	// ---------------------------------------------------------------
	logic               v_y2;
	srcl_pkg::pl_t      pl_y2;
	logic [1:0][DW-1:0] prod_y2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_y2 <= 1'b0;
		end else begin
			v_y2 <= v_y1;
		end
	end

	always_ff @(posedge clk) begin
		pl_y2 <= pl_y1;
		for (int k = 0; k < 2; k++) begin
			prod_y2[k] <= DW'(mo_y1[k]) * DW'(mag1(pl_y1.dx));
		end
	end

	// ---------------------------------------------------------------
	// y clip divider row: product / |dy|
	// ---------------------------------------------------------------
	logic           vy_d [0:QW];
	srcl_pkg::pl_t  ply_d[0:QW];
	srcl_pkg::div_t dvy_d[0:QW];

	always_comb begin
		vy_d[0]  = v_y2;
		ply_d[0] = pl_y2;
		for (int k = 0; k < 2; k++) begin
			dvy_d[0].rem[k] = RW'(prod_y2[k][DW-1:QW]);
			dvy_d[0].low[k] = prod_y2[k][QW-1:0];
			dvy_d[0].quo[k] = '0;
		end
		dvy_d[0].dvs = mag1(pl_y2.dy);
	end

	for (genvar i = 0; i < QW; i++) begin : g_ydiv
		srcl_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (vy_d[i]),
			.pl_i  (ply_d[i]),
			.dv_i  (dvy_d[i]),
			.vld_q (vy_d[i+1]),
			.pl_q  (ply_d[i+1]),
			.dv_q  (dvy_d[i+1])
		);
	end

	// ---------------------------------------------------------------
	// ye: new x of y-clipped endpoints, corner miss check
	// ---------------------------------------------------------------
	srcl_pkg::pl_t        pl_c4;
	logic [PW-1:0]        qy_c4;
	logic                 miss_c4;
	logic signed [PW-1:0] mx_c4, my_c4;

	always_comb begin
		pl_c4   = ply_d[QW];
		qy_c4   = '0;
		miss_c4 = 1'b0;
		mx_c4   = '0;
		my_c4   = '0;
		for (int k = 0; k < 2; k++) begin
			qy_c4 = PW'(dvy_d[QW].quo[k]);
			if (ply_d[QW].clip[k]) begin
				pl_c4.px[k] = ply_d[QW].neg[k] ? extw(ply_d[QW].sx) - qy_c4
				                               : extw(ply_d[QW].sx) + qy_c4;
			end
			mx_c4 = $signed(pl_c4.px[k]);
			my_c4 = $signed(pl_c4.py[k]);
			if (mx_c4 < extw(x_min_q) || mx_c4 > extw(x_max_q) ||
			    my_c4 < extw(y_min_q) || my_c4 > extw(y_max_q)) begin
				miss_c4 = 1'b1;
			end
		end
		// corner miss gives zero
		if (!ply_d[QW].early && miss_c4) begin
			pl_c4.early = 1'b1;
			pl_c4.len   = '0;
		end
	end

	logic          v_ye;
	srcl_pkg::pl_t pl_ye;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ye <= 1'b0;
		end else begin
			v_ye <= vy_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		pl_ye <= pl_c4;
	end

	// ---------------------------------------------------------------
	// ab: span magnitudes, zero for settled items
	// ---------------------------------------------------------------
	logic signed [PW-1:0] ddx_c5, ddy_c5;
	srcl_pkg::res_t       res_c5;

	always_comb begin
		ddx_c5 = $signed(pl_ye.px[1]) - $signed(pl_ye.px[0]);
		ddy_c5 = $signed(pl_ye.py[1]) - $signed(pl_ye.py[0]);
		if (ddx_c5[PW-1]) begin
			ddx_c5 = -ddx_c5;
		end
		if (ddy_c5[PW-1]) begin
			ddy_c5 = -ddy_c5;
		end
		res_c5.early   = pl_ye.early;
		res_c5.invalid = pl_ye.invalid;
		res_c5.len     = pl_ye.len;
	end

	logic           v_ab;
	srcl_pkg::res_t res_ab;
	logic [CW-1:0]  ax_ab, ay_ab;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ab <= 1'b0;
		end else begin
			v_ab <= v_ye;
		end
	end

	always_ff @(posedge clk) begin
		res_ab <= res_c5;
		ax_ab  <= pl_ye.early ? '0 : ddx_c5[CW-1:0];
		ay_ab  <= pl_ye.early ? '0 : ddy_c5[CW-1:0];
	end

	// ---------------------------------------------------------------
	// sq: squares, then sm: sum into the root row
	// ---------------------------------------------------------------
	logic            v_sq;
	srcl_pkg::res_t  res_sq;
	logic [2*CW-1:0] xx_sq, yy_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
		end else begin
			v_sq <= v_ab;
		end
	end

	always_ff @(posedge clk) begin
		res_sq <= res_ab;
		xx_sq  <= (2*CW)'(ax_ab) * (2*CW)'(ax_ab);
		yy_sq  <= (2*CW)'(ay_ab) * (2*CW)'(ay_ab);
	end

	logic           vr_d [0:RB];
	srcl_pkg::res_t rs_d [0:RB];
	srcl_pkg::sq_t  sq_d [0:RB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_d[0] <= 1'b0;
		end else begin
			vr_d[0] <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		rs_d[0]      <= res_sq;
		sq_d[0].rem  <= '0;
		sq_d[0].v    <= SQW'(xx_sq) + SQW'(yy_sq);
		sq_d[0].root <= '0;
	end

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		srcl_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (vr_d[i]),
			.res_i (rs_d[i]),
			.sq_i  (sq_d[i]),
			.vld_q (vr_d[i+1]),
			.res_q (rs_d[i+1]),
			.sq_q  (sq_d[i+1])
		);
	end

	// ---------------------------------------------------------------
	// result register, one-cycle strobe
	// ---------------------------------------------------------------
	logic          done_q;
	logic [LW-1:0] len_q;
	logic          inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vr_d[RB];
		end
	end

	always_ff @(posedge clk) begin
		inv_q <= rs_d[RB].invalid;
		if (rs_d[RB].invalid) begin
			len_q <= '0;
		end else if (rs_d[RB].early) begin
			len_q <= rs_d[RB].len;
		end else begin
			len_q <= LW'(sq_d[RB].root);
		end
	end

	assign done          = done_q;
	assign inside_length = len_q;
	assign rect_invalid  = inv_q;

	// radicand remainder width kept for the root row
	logic [RRW-1:0] unused_rem;
	assign unused_rem = sq_d[RB].rem;

endmodule

/* sv/srcl_checker.sv */
`include "segment_rect_clip_length_top_assert.svh"

module srcl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pready,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [srcl_pkg::LW-1:0]    inside_length,
	input logic                       rect_invalid
);

	`SRCL_ALWAYS(a_always_ready, clk, arst_n, pready && !busy)
	`SRCL_IMPLY(a_invalid_zero, clk, arst_n, done && rect_invalid, inside_length == '0)
	`SRCL_IMPLY(a_fixed_latency, clk, arst_n, done, $past(start && !busy, srcl_pkg::LAT))

endmodule

bind segment_rect_clip_length_top srcl_checker u_srcl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.inside_length(inside_length),
	.rect_invalid (rect_invalid)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	typedef srcl_pkg::coord_t coord_t;
	localparam int LW = srcl_pkg::LW;

	// rectangle register byte addresses
	localparam logic [3:0] REG_X_MIN = 4'd0;
	localparam logic [3:0] REG_X_MAX = 4'd4;
	localparam logic [3:0] REG_Y_MIN = 4'd8;
	localparam logic [3:0] REG_Y_MAX = 4'd12;
	localparam int STALL_LIMIT = 2000;   // far above the pipeline depth
	localparam int DRAIN_CYCLES = 130;
	localparam logic [LW-1:0] LEN_SAT = {LW{1'b1}};

	typedef struct {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} segment_t;

	typedef struct {
		logic [LW-1:0] len;
		logic          invalid;
	} clip_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic done;
	logic [LW-1:0] inside_length;
	logic rect_invalid;

	// testbench copy of the rectangle
	coord_t rx_min = '0, rx_max = '0, ry_min = '0, ry_max = '0;

	segment_t seg_q[$];            // segments waiting to be driven
	clip_result_t clip_len_q[$];   // predicted results in flight
	segment_t seg_cur;
	int idle_left = 0;
	bit idle_on = 1'b1;
	int errors = 0;
	int stall_cycles = 0;

	always #5 clk = ~clk;

	segment_rect_clip_length_top dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .start_x, .start_y, .end_x, .end_y,
		.done, .inside_length, .rect_invalid
	);

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// point on the segment's line: base + trunc(off * d_num / d_den)
	function automatic longint line_point(longint base, longint off, longint d_num,
			longint d_den);
		logic [127:0] prod;
		logic [127:0] quo;
		bit neg;
		prod = 128'(mag64(off)) * 128'(mag64(d_num));
		quo = prod / 128'(mag64(d_den));
		neg = ((off < 0) != (d_num < 0)) != (d_den < 0);
		return neg ? base - longint'(quo[63:0]) : base + longint'(quo[63:0]);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] v);
		logic [127:0] root;
		logic [127:0] trial;
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[63:0];
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// inside length of one segment against the current rectangle
	function automatic clip_result_t predict_clip_len(segment_t s);
		clip_result_t r;
		longint xl, xh, yl, yh, sx, sy, ex, ey, dx, dy;
		longint px[2], py[2];
		logic [63:0] ax, ay;
		logic [127:0] sq;
		logic [63:0] len;
		xl = rx_min; xh = rx_max; yl = ry_min; yh = ry_max;
		sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
		r.len = '0;
		r.invalid = 1'b0;
		if (xl > xh || yl > yh) begin
			r.invalid = 1'b1;
			return r;
		end
		// both endpoints beyond one side
		if ((sx < xl && ex < xl) || (sx > xh && ex > xh) ||
				(sy < yl && ey < yl) || (sy > yh && ey > yh))
			return r;
		if (sx == ex) begin
			// vertical, also covers a single point
			if (sx < xl || sx > xh)
				return r;
			len = mag64(clamp(ey, yl, yh) - clamp(sy, yl, yh));
		end else if (sy == ey) begin
			if (sy < yl || sy > yh)
				return r;
			len = mag64(clamp(ex, xl, xh) - clamp(sx, xl, xh));
		end else begin
			dx = ex - sx;
			dy = ey - sy;
			px[0] = sx; py[0] = sy; px[1] = ex; py[1] = ey;
			for (int k = 0; k < 2; k++) begin
				if (px[k] < xl || px[k] > xh) begin
					px[k] = px[k] < xl ? xl : xh;
					py[k] = line_point(sy, px[k] - sx, dy, dx);
				end
				if (py[k] < yl || py[k] > yh) begin
					py[k] = py[k] < yl ? yl : yh;
					px[k] = line_point(sx, py[k] - sy, dx, dy);
				end
				// line passes by a corner
				if (px[k] < xl || px[k] > xh || py[k] < yl || py[k] > yh)
					return r;
			end
			ax = mag64(px[1] - px[0]);
			ay = mag64(py[1] - py[0]);
			sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
			len = floor_sqrt(sq);
		end
		r.len = len > 64'(LEN_SAT) ? LEN_SAT : len[LW-1:0];
		return r;
	endfunction

	// command driver: one nonblocking write per signal per edge
	always @(posedge clk or negedge arst_n) begin
		segment_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				clip_len_q.push_back(predict_clip_len(seg_cur));
			if (start && busy) begin
				// beat still waiting, hold it
			end else if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
			end else if (seg_q.size() > 0) begin
				nxt = seg_q.pop_front();
				seg_cur <= nxt;
				start_x <= nxt.sx;
				start_y <= nxt.sy;
				end_x <= nxt.ex;
				end_y <= nxt.ey;
				start <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0)
					idle_left <= $urandom_range(1, 14);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor, done is a one cycle strobe
	always @(posedge clk) begin
		clip_result_t want;
		if (arst_n && done) begin
			if (clip_len_q.size() == 0) begin
				$error("result beat with nothing predicted: len %0d", inside_length);
				errors++;
			end else begin
				want = clip_len_q.pop_front();
				if (inside_length !== want.len) begin
					$error("inside_length expected %0d actual %0d", want.len, inside_length);
					errors++;
				end
				if (rect_invalid !== want.invalid) begin
					$error("rect_invalid expected %0d actual %0d", want.invalid,
						rect_invalid);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic apb_write(logic [3:0] addr, coord_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_X_MIN: rx_min = val;
			REG_X_MAX: rx_max = val;
			REG_Y_MIN: ry_min = val;
			default:   ry_max = val;
		endcase
	endtask

	task automatic set_rect(coord_t xl, coord_t xh, coord_t yl, coord_t yh);
		apb_write(REG_X_MIN, xl);
		apb_write(REG_X_MAX, xh);
		apb_write(REG_Y_MIN, yl);
		apb_write(REG_Y_MAX, yh);
	endtask

	task automatic add_seg(longint sx, longint sy, longint ex, longint ey);
		segment_t s;
		s.sx = coord_t'(sx);
		s.sy = coord_t'(sy);
		s.ex = coord_t'(ex);
		s.ey = coord_t'(ey);
		seg_q.push_back(s);
	endtask

	// wait until every beat is driven and every result is back
	task automatic drain();
		do
			@(negedge clk);
		while (seg_q.size() > 0 || start || clip_len_q.size() > 0);
	endtask

	// coordinate near one axis of the rectangle, sometimes anywhere
	function automatic longint pick_coord(longint lo, longint hi);
		longint span;
		span = (hi > lo ? hi - lo : lo - hi) + 64;
		case ($urandom_range(0, 5))
			0:       return longint'(coord_t'($urandom));
			1:       return lo;
			2:       return hi;
			default: return lo - span + longint'($urandom_range(0, 32'(3 * span) & 32'h7fffffff));
		endcase
	endfunction

	task automatic random_segs(int n);
		longint sx, sy, ex, ey;
		for (int i = 0; i < n; i++) begin
			sx = pick_coord(rx_min, rx_max);
			sy = pick_coord(ry_min, ry_max);
			ex = pick_coord(rx_min, rx_max);
			ey = pick_coord(ry_min, ry_max);
			case ($urandom_range(0, 11))
				0, 1: ex = sx;                 // vertical
				2, 3: ey = sy;                 // horizontal
				4: begin ex = sx; ey = sy; end // single point
				default: ;
			endcase
			add_seg(sx, sy, ex, ey);
		end
	endtask

	// random rectangle with small edges, the x low edge above its high one now and then
	task automatic random_rect();
		longint a, b, c, d, t;
		a = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
		b = a + longint'($urandom_range(0, 1 << 18));
		c = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
		d = c + longint'($urandom_range(0, 1 << 18));
		if ($urandom_range(0, 7) == 0) begin
			t = a; a = b + 1; b = t;
		end
		set_rect(coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d));
	endtask

	localparam longint CMIN = -64'sd2147483648;
	localparam longint CMAX = 64'sd2147483647;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset rectangle is the single point at the origin
		add_seg(0, 0, 0, 0);
		add_seg(-256, 0, 256, 0);
		add_seg(-256, -256, 256, 256);
		drain();

		// directed: rectangle x in [-4, 8], y in [-2, 6] (Q.8)
		set_rect(-1024, 2048, -512, 1536);
		add_seg(0, 0, 256, 512);             // fully inside
		add_seg(-4096, 0, 4096, 256);        // crosses the left and right edges
		add_seg(0, -4096, 256, 4096);        // crosses the bottom and top edges
		add_seg(-4096, 0, -2048, 512);       // both left, quick reject
		add_seg(3000, 0, 4000, 100);         // both right
		add_seg(0, -900, 100, -600);         // both below
		add_seg(0, 1600, 100, 2000);         // both above
		add_seg(100, -4096, 100, 4096);      // vertical, clamped
		add_seg(3000, -100, 3000, 100);      // vertical outside in x
		add_seg(-4096, 200, 4096, 200);      // horizontal, clamped
		add_seg(-100, 1600, 100, 1600);      // horizontal outside in y
		add_seg(500, 500, 500, 500);         // single point inside
		add_seg(-2000, 1400, -900, 2500);    // corner miss near top left
		add_seg(-1024, -512, 2048, 1536);    // corner to corner
		add_seg(CMIN, CMIN, CMAX, CMAX);     // field extremes
		add_seg(CMAX, CMIN, CMIN, CMAX);
		drain();

		// full range rectangle, lengths up to the full diagonal
		set_rect(coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMAX));
		add_seg(CMIN, CMIN, CMAX, CMAX);
		add_seg(CMIN, 0, CMAX, 0);
		add_seg(0, CMAX, 0, CMIN);
		add_seg(CMIN, CMAX, CMAX, CMIN + 1);
		random_segs(60);
		drain();

		// low edges above high edges
		set_rect(256, -256, 0, 256);
		add_seg(0, 0, 100, 100);
		drain();
		set_rect(0, 256, 256, -256);
		add_seg(0, 0, 100, 100);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			random_rect();
			random_segs(100);
			drain();
		end

		// closing phase runs back to back
		idle_on = 1'b0;
		random_rect();
		random_segs(60);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/srcl_pkg.sv
sv/srcl_div_cell.sv
sv/srcl_sqrt_cell.sv
sv/segment_rect_clip_length_top.sv
sv/srcl_checker.sv
tb/tb_top.sv
